// ----- src/fees_pkg.sv -----
package fees_pkg;

	localparam int FRAME_W = 64;
	localparam int TAG_W = 8;
	localparam int VAL_W = 48;

	localparam logic [TAG_W-1:0] TAG_NULL = 8'h00;
	localparam logic [TAG_W-1:0] TAG_ERASED = 8'hff;
	localparam logic [7:0] MARK_VALID = 8'h55;
	localparam logic [7:0] MARK_MOVING = 8'h00;
	localparam logic [1:0] BANK_NONE = 2'd2;
	localparam logic [5:0] VOTE_LO = 6'd8;
	localparam logic [5:0] VOTE_HI = 6'd24;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NOT_FOUND,
		ST_NO_SPACE,
		ST_BAD_TAG,
		ST_NO_BANK,
		ST_BANK_ERR
	} status_t;

	typedef enum logic [1:0] {
		MODE_READ,
		MODE_WRITE,
		MODE_MOUNT,
		MODE_FORMAT
	} mode_t;

	typedef enum logic [1:0] {
		PG_ERASED,
		PG_VALID,
		PG_MOVING,
		PG_INVALID
	} hdr_t;

	typedef enum logic [5:0] {
		S_CLR,
		S_IDLE,
		S_START,
		S_SCAN_RD,
		S_SCAN_EV,
		S_PROG_RD,
		S_PROG_WR,
		S_SET_RD,
		S_SET_WR,
		S_PS_RD,
		S_PS_EV,
		S_ERASE,
		S_R_FIN,
		S_W_SCAN,
		S_F_CLR,
		S_F_RD,
		S_F_EV,
		S_F_SEEN,
		S_W_ALT,
		S_W_ALT_CHK,
		S_W_MIG,
		S_W_MIG_DONE,
		S_W_ER,
		S_W_FIN,
		S_M_RD,
		S_M_EV,
		S_M_AFTER,
		S_MT,
		S_MT_PS0,
		S_MT_PS1,
		S_MT_MIGD,
		S_MT_SETV,
		S_MT_TAKE,
		S_DONE
	} state_t;

	function automatic logic [7:0] check_byte(logic [TAG_W-1:0] tag, logic [VAL_W-1:0] val);
		logic [7:0] c;
		c = tag;
		for (int i = 0; i < 6; i++) begin
			c = c ^ val[8*i +: 8];
		end
		return c;
	endfunction

	function automatic logic frame_good(logic [FRAME_W-1:0] f);
		logic [TAG_W-1:0] t;
		t = f[7:0];
		return (t != TAG_NULL) && (t != TAG_ERASED) && (f[63:56] == check_byte(t, f[55:8]));
	endfunction

	function automatic logic [FRAME_W-1:0] pack_frame(logic [TAG_W-1:0] tag,
			logic [VAL_W-1:0] val);
		return {check_byte(tag, val), val, tag};
	endfunction

	function automatic logic [5:0] pop32(logic [31:0] v);
		logic [2:0] nib [8];
		logic [5:0] s;
		for (int i = 0; i < 8; i++) begin
			nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
		end
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(nib[i]);
		end
		return s;
	endfunction

	// bit-count vote over even and odd positions of the header frame
	function automatic hdr_t hdr_decode(logic [FRAME_W-1:0] f);
		logic [31:0] ev;
		logic [31:0] od;
		logic [5:0] ce;
		logic [5:0] co;
		hdr_t h;
		for (int i = 0; i < 32; i++) begin
			ev[i] = f[2*i];
			od[i] = f[2*i+1];
		end
		ce = pop32(ev);
		co = pop32(od);
		if ((ce > VOTE_LO && ce < VOTE_HI) || (co > VOTE_LO && co < VOTE_HI)) begin
			h = PG_INVALID;
		end else begin
			case ({co >= VOTE_HI, ce >= VOTE_HI})
				2'b00: h = PG_MOVING;
				2'b01: h = PG_VALID;
				2'b11: h = PG_ERASED;
				default: h = PG_INVALID;
			endcase
		end
		return h;
	endfunction

endpackage

// ----- src/fees_req_if.sv -----
interface fees_req_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [7:0] tag;
	logic [47:0] value;

	modport source(output valid, output mode, output tag, output value, input ready);
	modport sink(input valid, input mode, input tag, input value, output ready);
endinterface

// ----- src/fees_rsp_if.sv -----
interface fees_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [47:0] read_value;
	logic [1:0] active_bank;

	modport source(output valid, output status, output read_value, output active_bank,
		input ready);
	modport sink(input valid, input status, input read_value, input active_bank,
		output ready);
endinterface

// ----- src/flash_eeprom_emulation_store.sv -----
// Two-bank log-structured tag/value store. One word in on req, one word out on rsp; req is
// ready only while the block is idle. Each bank is a memory whose read and write share one
// address, and every access walks it one frame at a time. A write that fills the bank first
// checks for stale copies (clearing the tag map, then reading each frame once), then
// compacts: each good source frame costs a full scan of the other bank, and each bank
// erase is a pass over all FRAMES_PER_BANK frames. After reset both banks are erased by a
// clearing pass before the first word is taken; format likewise erases both banks before
// mounting.
module flash_eeprom_emulation_store #(
	parameter int FRAMES_PER_BANK = 64
) (
	input logic clk,
	input logic arst_n,
	fees_req_if.sink req,
	fees_rsp_if.source rsp
);
	import fees_pkg::*;

	localparam int AW = (FRAMES_PER_BANK > 1) ? $clog2(FRAMES_PER_BANK) : 1;
	localparam int CW = $clog2(FRAMES_PER_BANK + 1);
	localparam logic [CW-1:0] N_LAST = CW'(FRAMES_PER_BANK - 1);
	localparam logic [CW-1:0] N_FULL = CW'(FRAMES_PER_BANK);
	localparam logic [CW-1:0] N_ONE = CW'(1);
	localparam logic [AW-1:0] M_ONE = AW'(1);

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	state_t mig_ret_q, mig_ret_d;
	logic [CW-1:0] n_q, n_d;
	logic [AW-1:0] mn_q, mn_d;
	logic [7:0] clr_q, clr_d;
	logic [1:0] active_q, active_d;
	logic [1:0] mode_q, mode_d;
	logic [TAG_W-1:0] tag_q, tag_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic sel_q, sel_d;
	logic rsel_q, rsel_c;
	logic [TAG_W-1:0] key_q, key_d;
	logic [TAG_W-1:0] ptag_q, ptag_d;
	logic [VAL_W-1:0] pval_q, pval_d;
	logic hit_q, hit_d;
	logic [VAL_W-1:0] last_q, last_d;
	hdr_t ps_q, ps_d;
	hdr_t e0_q, e0_d;
	status_t st_q, st_d;
	status_t mig_st_q, mig_st_d;
	logic [VAL_W-1:0] rv_q, rv_d;
	logic final_q, final_d;
	logic [1:0] emask_q, emask_d;
	logic [7:0] hdr_q, hdr_d;
	logic mig_src_q, mig_src_d;
	logic good_q, good_d;
	logic [TAG_W-1:0] t_q, t_d;

	logic [AW-1:0] addr_c;
	logic we0_c, we1_c;
	logic [FRAME_W-1:0] wdata_c;
	logic [FRAME_W-1:0] q0, q1, rd_frame;
	logic seen_we_c, seen_wdata_c, seen_rdata;
	logic [7:0] seen_waddr_c, seen_raddr_c;
	logic v0, v1;
	hdr_t eo;

	fees_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES_PER_BANK)) u_bank0 (
		.clk(clk), .we(we0_c), .waddr(addr_c), .wdata(wdata_c), .raddr(addr_c), .rdata(q0)
	);

	fees_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES_PER_BANK)) u_bank1 (
		.clk(clk), .we(we1_c), .waddr(addr_c), .wdata(wdata_c), .raddr(addr_c), .rdata(q1)
	);

	fees_ram #(.WIDTH(1), .DEPTH(256)) u_seen (
		.clk(clk), .we(seen_we_c), .waddr(seen_waddr_c), .wdata(seen_wdata_c),
		.raddr(seen_raddr_c), .rdata(seen_rdata)
	);

	assign rd_frame = rsel_q ? q1 : q0;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_DONE);
	assign rsp.status = st_q;
	assign rsp.read_value = rv_q;
	assign rsp.active_bank = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			n_q <= '0;
			clr_q <= '0;
			active_q <= BANK_NONE;
		end else begin
			state_q <= state_d;
			n_q <= n_d;
			clr_q <= clr_d;
			active_q <= active_d;
		end
	end

	always_ff @(posedge clk) begin
		ret_q <= ret_d;
		mig_ret_q <= mig_ret_d;
		mn_q <= mn_d;
		mode_q <= mode_d;
		tag_q <= tag_d;
		val_q <= val_d;
		sel_q <= sel_d;
		rsel_q <= rsel_c;
		key_q <= key_d;
		ptag_q <= ptag_d;
		pval_q <= pval_d;
		hit_q <= hit_d;
		last_q <= last_d;
		ps_q <= ps_d;
		e0_q <= e0_d;
		st_q <= st_d;
		mig_st_q <= mig_st_d;
		rv_q <= rv_d;
		final_q <= final_d;
		emask_q <= emask_d;
		hdr_q <= hdr_d;
		mig_src_q <= mig_src_d;
		good_q <= good_d;
		t_q <= t_d;
	end

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		mig_ret_d = mig_ret_q;
		n_d = n_q;
		mn_d = mn_q;
		clr_d = clr_q;
		active_d = active_q;
		mode_d = mode_q;
		tag_d = tag_q;
		val_d = val_q;
		sel_d = sel_q;
		rsel_c = sel_q;
		key_d = key_q;
		ptag_d = ptag_q;
		pval_d = pval_q;
		hit_d = hit_q;
		last_d = last_q;
		ps_d = ps_q;
		e0_d = e0_q;
		st_d = st_q;
		mig_st_d = mig_st_q;
		rv_d = rv_q;
		final_d = final_q;
		emask_d = emask_q;
		hdr_d = hdr_q;
		mig_src_d = mig_src_q;
		good_d = good_q;
		t_d = t_q;
		addr_c = n_q[AW-1:0];
		we0_c = 1'b0;
		we1_c = 1'b0;
		wdata_c = '1;
		seen_we_c = 1'b0;
		seen_waddr_c = t_q;
		seen_wdata_c = 1'b1;
		seen_raddr_c = rd_frame[7:0];
		v0 = (e0_q == PG_VALID);
		v1 = (ps_q == PG_VALID);
		eo = v0 ? ps_q : e0_q;

		unique case (state_q)
			S_CLR: begin
				we0_c = 1'b1;
				we1_c = 1'b1;
				if (n_q == N_LAST) begin
					state_d = S_IDLE;
				end else begin
					n_d = n_q + N_ONE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					mode_d = req.mode;
					tag_d = req.tag;
					val_d = req.value;
					rv_d = '0;
					final_d = 1'b0;
					state_d = S_START;
				end
			end
			S_START: begin
				unique case (mode_t'(mode_q))
					MODE_READ: begin
						if (active_q == BANK_NONE) begin
							st_d = ST_NO_BANK;
							state_d = S_DONE;
						end else begin
							sel_d = active_q[0];
							key_d = tag_q;
							n_d = N_ONE;
							hit_d = 1'b0;
							ret_d = S_R_FIN;
							state_d = S_SCAN_RD;
						end
					end
					MODE_WRITE: begin
						if (tag_q == TAG_NULL || tag_q == TAG_ERASED) begin
							st_d = ST_BAD_TAG;
							state_d = S_DONE;
						end else if (active_q == BANK_NONE) begin
							st_d = ST_NO_BANK;
							state_d = S_DONE;
						end else begin
							sel_d = active_q[0];
							key_d = tag_q;
							n_d = N_ONE;
							hit_d = 1'b0;
							ret_d = S_W_SCAN;
							state_d = S_SCAN_RD;
						end
					end
					MODE_MOUNT: begin
						state_d = S_MT;
					end
					MODE_FORMAT: begin
						active_d = BANK_NONE;
						emask_d = 2'b11;
						n_d = '0;
						ret_d = S_MT;
						state_d = S_ERASE;
					end
					default: state_d = S_MT;
				endcase
			end
			S_SCAN_RD: begin
				if (n_q == N_FULL) begin
					state_d = ret_q;
				end else begin
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				if (rd_frame[7:0] == TAG_ERASED) begin
					state_d = ret_q;
				end else begin
					if (rd_frame[7:0] == key_q && frame_good(rd_frame)) begin
						hit_d = 1'b1;
						last_d = rd_frame[55:8];
					end
					n_d = n_q + N_ONE;
					state_d = S_SCAN_RD;
				end
			end
			S_PROG_RD: begin
				state_d = S_PROG_WR;
			end
			S_PROG_WR: begin
				we0_c = !sel_q;
				we1_c = sel_q;
				wdata_c = rd_frame & pack_frame(ptag_q, pval_q);
				state_d = ret_q;
			end
			S_SET_RD: begin
				addr_c = '0;
				state_d = S_SET_WR;
			end
			S_SET_WR: begin
				addr_c = '0;
				we0_c = !sel_q;
				we1_c = sel_q;
				wdata_c = rd_frame & {8{hdr_q}};
				state_d = ret_q;
			end
			S_PS_RD: begin
				addr_c = '0;
				state_d = S_PS_EV;
			end
			S_PS_EV: begin
				ps_d = hdr_decode(rd_frame);
				state_d = ret_q;
			end
			S_ERASE: begin
				we0_c = emask_q[0];
				we1_c = emask_q[1];
				if (n_q == N_LAST) begin
					state_d = ret_q;
				end else begin
					n_d = n_q + N_ONE;
				end
			end
			S_R_FIN: begin
				if (hit_q) begin
					st_d = ST_OK;
					rv_d = last_q;
				end else begin
					st_d = ST_NOT_FOUND;
				end
				state_d = S_DONE;
			end
			S_W_SCAN: begin
				if (hit_q && last_q == val_q) begin
					st_d = ST_OK;
					state_d = S_DONE;
				end else if (n_q == N_FULL) begin
					if (final_q) begin
						st_d = ST_NO_SPACE;
						state_d = S_DONE;
					end else begin
						clr_d = '0;
						state_d = S_F_CLR;
					end
				end else begin
					ptag_d = tag_q;
					pval_d = val_q;
					st_d = ST_OK;
					ret_d = S_DONE;
					state_d = S_PROG_RD;
				end
			end
			S_F_CLR: begin
				seen_we_c = 1'b1;
				seen_waddr_c = clr_q;
				seen_wdata_c = 1'b0;
				clr_d = clr_q + 8'd1;
				if (clr_q == 8'hff) begin
					n_d = N_ONE;
					state_d = S_F_RD;
				end
			end
			S_F_RD: begin
				if (n_q == N_FULL) begin
					st_d = ST_NO_SPACE;
					state_d = S_DONE;
				end else begin
					state_d = S_F_EV;
				end
			end
			S_F_EV: begin
				if (rd_frame[7:0] == TAG_ERASED) begin
					state_d = S_W_ALT;
				end else if (!frame_good(rd_frame)) begin
					n_d = n_q + N_ONE;
					state_d = S_F_RD;
				end else begin
					t_d = rd_frame[7:0];
					state_d = S_F_SEEN;
				end
			end
			S_F_SEEN: begin
				if (seen_rdata) begin
					state_d = S_W_ALT;
				end else begin
					seen_we_c = 1'b1;
					n_d = n_q + N_ONE;
					state_d = S_F_RD;
				end
			end
			S_W_ALT: begin
				sel_d = !active_q[0];
				ret_d = S_W_ALT_CHK;
				state_d = S_PS_RD;
			end
			S_W_ALT_CHK: begin
				if (ps_q != PG_ERASED) begin
					st_d = ST_BANK_ERR;
					state_d = S_DONE;
				end else begin
					sel_d = active_q[0];
					hdr_d = MARK_MOVING;
					ret_d = S_W_MIG;
					state_d = S_SET_RD;
				end
			end
			S_W_MIG: begin
				mig_src_d = active_q[0];
				mn_d = N_LAST[AW-1:0];
				mig_st_d = ST_OK;
				mig_ret_d = S_W_MIG_DONE;
				state_d = S_M_RD;
			end
			S_W_MIG_DONE: begin
				if (mig_st_q != ST_OK) begin
					st_d = mig_st_q;
					state_d = S_DONE;
				end else begin
					sel_d = !active_q[0];
					hdr_d = MARK_VALID;
					ret_d = S_W_ER;
					state_d = S_SET_RD;
				end
			end
			S_W_ER: begin
				emask_d = active_q[0] ? 2'b10 : 2'b01;
				n_d = '0;
				ret_d = S_W_FIN;
				state_d = S_ERASE;
			end
			S_W_FIN: begin
				active_d = {1'b0, !active_q[0]};
				sel_d = !active_q[0];
				key_d = tag_q;
				n_d = N_ONE;
				hit_d = 1'b0;
				final_d = 1'b1;
				ret_d = S_W_SCAN;
				state_d = S_SCAN_RD;
			end
			S_M_RD: begin
				addr_c = mn_q;
				rsel_c = mig_src_q;
				if (mn_q == '0) begin
					state_d = mig_ret_q;
				end else begin
					state_d = S_M_EV;
				end
			end
			S_M_EV: begin
				if (!frame_good(rd_frame)) begin
					mn_d = mn_q - M_ONE;
					state_d = S_M_RD;
				end else begin
					ptag_d = rd_frame[7:0];
					pval_d = rd_frame[55:8];
					key_d = rd_frame[7:0];
					sel_d = !mig_src_q;
					n_d = N_ONE;
					hit_d = 1'b0;
					ret_d = S_M_AFTER;
					state_d = S_SCAN_RD;
				end
			end
			S_M_AFTER: begin
				mn_d = mn_q - M_ONE;
				if (hit_q) begin
					state_d = S_M_RD;
				end else if (n_q == N_FULL) begin
					mig_st_d = ST_NO_SPACE;
					state_d = S_M_RD;
				end else begin
					mig_st_d = ST_OK;
					ret_d = S_M_RD;
					state_d = S_PROG_RD;
				end
			end
			S_MT: begin
				sel_d = 1'b0;
				ret_d = S_MT_PS0;
				state_d = S_PS_RD;
			end
			S_MT_PS0: begin
				e0_d = ps_q;
				sel_d = 1'b1;
				ret_d = S_MT_PS1;
				state_d = S_PS_RD;
			end
			S_MT_PS1: begin
				active_d = BANK_NONE;
				if (v0 != v1) begin
					good_d = v1;
					if (eo == PG_MOVING) begin
						mig_src_d = !v1;
						mn_d = N_LAST[AW-1:0];
						mig_st_d = ST_OK;
						mig_ret_d = S_MT_MIGD;
						state_d = S_M_RD;
					end else begin
						state_d = S_MT_TAKE;
					end
				end else begin
					good_d = 1'b0;
					if (!(e0_q == PG_ERASED && ps_q == PG_ERASED)) begin
						emask_d = 2'b11;
						n_d = '0;
						ret_d = S_MT_SETV;
						state_d = S_ERASE;
					end else begin
						state_d = S_MT_SETV;
					end
				end
			end
			S_MT_MIGD: begin
				if (mig_st_q != ST_OK) begin
					st_d = ST_NO_SPACE;
					state_d = S_DONE;
				end else begin
					emask_d = good_q ? 2'b01 : 2'b10;
					n_d = '0;
					ret_d = S_MT_TAKE;
					state_d = S_ERASE;
				end
			end
			S_MT_SETV: begin
				sel_d = 1'b0;
				hdr_d = MARK_VALID;
				ret_d = S_MT_TAKE;
				state_d = S_SET_RD;
			end
			S_MT_TAKE: begin
				active_d = {1'b0, good_q};
				st_d = ST_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- src/fees_ram.sv -----
module fees_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
